FILE: rtl/acfc_pkg.sv
// shared types, codes and helper functions for the ascii command frame checker
`default_nettype none

package acfc_pkg;

    localparam int CHAR_W   = 8;
    localparam int CRC_W    = 8;
    localparam int LEN_W    = 13;
    localparam int PCOUNT_W = 4;
    localparam int STATUS_W = 3;

    localparam logic [CRC_W-1:0]  CRC_SEED    = 8'hA5;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 8'h07;
    localparam logic [LEN_W-1:0]  LEN_MAX     = 13'h1FFF;
    localparam logic [LEN_W-1:0]  BUF_SIZE_RST = 13'd128;
    localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_SIGN   = 8'h40;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_BAD_CRC   = 3'd3,
        ST_BAD_SIGN  = 3'd4
    } status_t;

    // verdict on the first non-empty token
    typedef enum logic [1:0] {
        FV_NONE  = 2'd0,
        FV_SIGN  = 2'd1,
        FV_OTHER = 2'd2
    } first_verdict_t;

    typedef struct packed {
        status_t                 status;
        logic [PCOUNT_W-1:0]     param_count;
        logic [CRC_W-1:0]        computed_crc;
    } result_t;

    // crc-8, msb first, one byte
    function automatic logic [CRC_W-1:0] crc8_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [CHAR_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (crc[CRC_W-1])
                crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[CRC_W-2:0], 1'b0};
        end
        return crc;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            v = {1'b0, 4'(c - 8'h37)};
        else
            v = 5'h10;
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acfc_if.sv
// valid/ready channel interfaces for input characters and frame results
`default_nettype none

interface acfc_in_if;
    logic                             valid;
    logic                             ready;
    logic [acfc_pkg::CHAR_W-1:0]      char_byte;
    logic                             frame_end;

    modport source (output valid, output char_byte, output frame_end, input ready);
    modport sink   (input valid, input char_byte, input frame_end, output ready);
endinterface

interface acfc_out_if;
    logic                             valid;
    logic                             ready;
    logic [acfc_pkg::STATUS_W-1:0]    status;
    logic [acfc_pkg::PCOUNT_W-1:0]    param_count;
    logic [acfc_pkg::CRC_W-1:0]       computed_crc;

    modport source (output valid, output status, output param_count,
                    output computed_crc, input ready);
    modport sink   (input valid, input status, input param_count,
                    input computed_crc, output ready);
endinterface

`default_nettype wire

FILE: rtl/acfc_tracker.sv
// per-frame state: running crc, comma snapshots, token counts, crc field and verdict
`default_nettype none

module acfc_tracker #(
    parameter int MAX_PARAMS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [acfc_pkg::CHAR_W-1:0]   char_byte,
    input  wire logic                          frame_end,
    input  wire logic [acfc_pkg::LEN_W-1:0]    buffer_size,
    output acfc_pkg::result_t                  result,
    output logic                               result_load
);

    localparam int TOKEN_CAP = MAX_PARAMS + 2;
    localparam int CNT_W     = $clog2(TOKEN_CAP + 1);
    localparam logic [CNT_W-1:0] TOKEN_CAP_C  = CNT_W'(TOKEN_CAP);
    localparam logic [CNT_W-1:0] MAX_PARAMS_C = CNT_W'(MAX_PARAMS);

    logic [acfc_pkg::CRC_W-1:0]  crc_reg,        crc_next;
    logic [acfc_pkg::CRC_W-1:0]  crc_comma_reg,  crc_comma_next;
    logic                        comma_seen_reg, comma_seen_next;
    logic [acfc_pkg::LEN_W-1:0]  len_reg,        len_next;
    logic [1:0]                  tail_len_reg,   tail_len_next;
    logic                        tail_hex_reg,   tail_hex_next;
    logic [7:0]                  tail_val_reg,   tail_val_next;
    logic [1:0]                  tok_len_reg,    tok_len_next;
    logic                        tok_sign_reg,   tok_sign_next;
    logic [CNT_W-1:0]            closed_reg,     closed_next;
    logic [CNT_W-1:0]            tal_reg,        tal_next;
    acfc_pkg::first_verdict_t    verdict_reg,    verdict_next;

    logic [4:0]       hex;
    logic             is_comma;
    logic [CNT_W-1:0] params;

    always_comb
    begin
        hex      = acfc_pkg::hex_value(char_byte);
        is_comma = (char_byte == acfc_pkg::CHAR_COMMA);

        len_next        = (len_reg != acfc_pkg::LEN_MAX) ? len_reg + 1'b1 : len_reg;
        crc_next        = acfc_pkg::crc8_byte(crc_reg, char_byte);
        crc_comma_next  = crc_comma_reg;
        comma_seen_next = comma_seen_reg;
        tail_len_next   = tail_len_reg;
        tail_hex_next   = tail_hex_reg;
        tail_val_next   = tail_val_reg;
        tok_len_next    = tok_len_reg;
        tok_sign_next   = tok_sign_reg;
        closed_next     = closed_reg;
        tal_next        = tal_reg;
        verdict_next    = verdict_reg;

        if (is_comma)
        begin
            crc_comma_next  = crc_reg;
            comma_seen_next = 1'b1;
            if (tok_len_reg != 2'd0)
            begin
                if (closed_reg == '0)
                    verdict_next = (tok_len_reg == 2'd1 && tok_sign_reg) ?
                                   acfc_pkg::FV_SIGN : acfc_pkg::FV_OTHER;
                if (closed_reg < TOKEN_CAP_C)
                    closed_next = closed_reg + 1'b1;
            end
            tal_next      = closed_next;
            tok_len_next  = 2'd0;
            tok_sign_next = 1'b0;
            tail_len_next = 2'd0;
            tail_hex_next = 1'b1;
            tail_val_next = 8'h00;
        end
        else
        begin
            if (tok_len_reg == 2'd0)
                tok_sign_next = (char_byte == acfc_pkg::CHAR_SIGN);
            if (tok_len_reg != 2'd2)
                tok_len_next = tok_len_reg + 1'b1;
            if (tail_len_reg != 2'd3)
                tail_len_next = tail_len_reg + 1'b1;
            if (hex[4])
                tail_hex_next = 1'b0;
            else
                tail_val_next = {tail_val_reg[3:0], hex[3:0]};
        end

        // status from the state after this character
        params = '0;
        if (len_next >= buffer_size)
            result.status = acfc_pkg::ST_TOO_LONG;
        else if (!comma_seen_next)
            result.status = acfc_pkg::ST_MALFORMED;
        else if (tail_len_next == 2'd0 || tail_len_next == 2'd3 || !tail_hex_next ||
                 tail_val_next != crc_comma_next)
            result.status = acfc_pkg::ST_BAD_CRC;
        else if (tal_next < CNT_W'(2))
            result.status = acfc_pkg::ST_MALFORMED;
        else if (verdict_next != acfc_pkg::FV_SIGN)
            result.status = acfc_pkg::ST_BAD_SIGN;
        else
        begin
            result.status = acfc_pkg::ST_OK;
            params = tal_next - CNT_W'(2);
            if (params > MAX_PARAMS_C)
                params = MAX_PARAMS_C;
        end
        result.param_count  = acfc_pkg::PCOUNT_W'(params);
        result.computed_crc = crc_comma_next;
        result_load         = accept && frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= acfc_pkg::CRC_SEED;
            crc_comma_reg  <= acfc_pkg::CRC_SEED;
            comma_seen_reg <= 1'b0;
            len_reg        <= '0;
            tail_len_reg   <= 2'd0;
            tail_hex_reg   <= 1'b1;
            tail_val_reg   <= 8'h00;
            tok_len_reg    <= 2'd0;
            tok_sign_reg   <= 1'b0;
            closed_reg     <= '0;
            tal_reg        <= '0;
            verdict_reg    <= acfc_pkg::FV_NONE;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                // frame done, start clean
                crc_reg        <= acfc_pkg::CRC_SEED;
                crc_comma_reg  <= acfc_pkg::CRC_SEED;
                comma_seen_reg <= 1'b0;
                len_reg        <= '0;
                tail_len_reg   <= 2'd0;
                tail_hex_reg   <= 1'b1;
                tail_val_reg   <= 8'h00;
                tok_len_reg    <= 2'd0;
                tok_sign_reg   <= 1'b0;
                closed_reg     <= '0;
                tal_reg        <= '0;
                verdict_reg    <= acfc_pkg::FV_NONE;
            end
            else
            begin
                crc_reg        <= crc_next;
                crc_comma_reg  <= crc_comma_next;
                comma_seen_reg <= comma_seen_next;
                len_reg        <= len_next;
                tail_len_reg   <= tail_len_next;
                tail_hex_reg   <= tail_hex_next;
                tail_val_reg   <= tail_val_next;
                tok_len_reg    <= tok_len_next;
                tok_sign_reg   <= tok_sign_next;
                closed_reg     <= closed_next;
                tal_reg        <= tal_next;
                verdict_reg    <= verdict_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acfc_out_reg.sv
// result register with valid/ready toward the receiver
`default_nettype none

module acfc_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire acfc_pkg::result_t  result,
    output logic                    space,
    acfc_out_if.source              out
);

    logic              valid_reg, valid_next;
    acfc_pkg::result_t data_reg;

    always_comb
    begin
        space      = !valid_reg || out.ready;
        valid_next = load || (valid_reg && !out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out.valid        = valid_reg;
    assign out.status       = data_reg.status;
    assign out.param_count  = data_reg.param_count;
    assign out.computed_crc = data_reg.computed_crc;

endmodule

`default_nettype wire

FILE: rtl/ascii_command_frame_checker_core.sv
// top level of the ascii command frame checker
//
// channels: "in" carries one character word per handshake (char_byte, with
// frame_end marking the last character of a frame); "out" carries one
// result word per frame (status, param_count, computed_crc)
// configuration: cfg_we/cfg_wdata write buffer_size (reset 128); write it
// only while no frame is in progress and no result is pending
// throughput: one character per cycle, back to back, including across frames
// latency: the result of a frame shows on "out" the cycle after its
// frame_end character is taken
// the frame state and crc update sit between the input handshake and a
// single result register; a character that ends no frame only updates state
// stall: while a result waits and out.ready is low, in.ready drops; as soon
// as the receiver takes the result a new character is accepted in the same
// cycle
// reset: asynchronous, active low; clears the frame state to the crc seed
// and empty counters, empties the result register, sets buffer_size to 128
`default_nettype none

module ascii_command_frame_checker_core #(
    parameter int MAX_PARAMS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    acfc_in_if.sink                          in,
    acfc_out_if.source                       out,
    input  wire logic                        cfg_we,
    input  wire logic [acfc_pkg::LEN_W-1:0]  cfg_wdata
);

    // frame length limit
    logic [acfc_pkg::LEN_W-1:0] buf_size_reg;

    logic              space;
    logic              accept;
    logic              result_load;
    acfc_pkg::result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buf_size_reg <= acfc_pkg::BUF_SIZE_RST;
        else if (cfg_we)
            buf_size_reg <= cfg_wdata;
    end

    // take a word whenever the result register can absorb a possible result
    assign in.ready = space;
    assign accept   = in.valid && space;

    acfc_tracker #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_byte   (in.char_byte),
        .frame_end   (in.frame_end),
        .buffer_size (buf_size_reg),
        .result      (result),
        .result_load (result_load)
    );

    acfc_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (result_load),
        .result (result),
        .space  (space),
        .out    (out)
    );

endmodule

`default_nettype wire

FILE: rtl/acfc_checker.sv
// port-level assertions for the frame checker and their bind
`default_nettype none

module acfc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           in_frame_end,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [acfc_pkg::STATUS_W-1:0]  out_status,
    input wire logic [acfc_pkg::PCOUNT_W-1:0]  out_param_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("result changed while stalled");

    // a frame end word yields a result in the next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_frame_end |=> out_valid)
        else $error("no result after frame end");

    // no result appears without a frame end
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) && !(in_valid && in_ready && in_frame_end)
        |=> !out_valid)
        else $error("result without frame end");

    // parameter count is zero unless the frame is ok
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != acfc_pkg::ST_OK |-> out_param_count == '0)
        else $error("parameter count on failed frame");

    // never refuse input while the result register is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind ascii_command_frame_checker_core acfc_checker u_acfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in.valid),
    .in_ready        (in.ready),
    .in_frame_end    (in.frame_end),
    .out_valid       (out.valid),
    .out_ready       (out.ready),
    .out_status      (out.status),
    .out_param_count (out.param_count)
);

`default_nettype wire

FILE: test/ascii_command_frame_checker_core_tb.sv
// self-checking testbench for the ascii command frame checker core
`timescale 1ns / 100ps

module ascii_command_frame_checker_core_tb;

    localparam int MAX_PARAMS = 8;
    localparam int TOKEN_CAP  = MAX_PARAMS + 2;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        TAIL_GOOD,
        TAIL_WRONG,
        TAIL_LONG,
        TAIL_NON_HEX,
        TAIL_EMPTY,
        TAIL_NONE
    } tail_kind_t;

    // frame state mirror and the queue of verdicts still owed by the block
    class frame_checker_model_t;
        logic [acfc_pkg::LEN_W-1:0] buffer_size;
        logic [acfc_pkg::CRC_W-1:0] crc_run;
        logic [acfc_pkg::CRC_W-1:0] crc_at_comma;
        bit                         comma_seen;
        logic [acfc_pkg::LEN_W-1:0] frame_len;
        logic [1:0]                 tail_len;
        bit                         tail_hex;
        logic [7:0]                 tail_val;
        logic [1:0]                 tok_len;
        bit                         tok_sign;
        logic [3:0]                 tokens_closed;
        logic [3:0]                 tokens_at_comma;
        acfc_pkg::first_verdict_t   verdict;
        acfc_pkg::result_t          awaited_verdicts[$];
        int                         mismatch_count;

        function new();
            buffer_size    = acfc_pkg::BUF_SIZE_RST;
            mismatch_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc_run         = acfc_pkg::CRC_SEED;
            crc_at_comma    = acfc_pkg::CRC_SEED;
            comma_seen      = 1'b0;
            frame_len       = '0;
            tail_len        = '0;
            tail_hex        = 1'b1;
            tail_val        = '0;
            tok_len         = '0;
            tok_sign        = 1'b0;
            tokens_closed   = '0;
            tokens_at_comma = '0;
            verdict         = acfc_pkg::FV_NONE;
        endfunction

        // bit-serial form, one input bit per step, msb first
        static function logic [acfc_pkg::CRC_W-1:0] crc_step(
            input logic [acfc_pkg::CRC_W-1:0] crc,
            input logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb  = crc[acfc_pkg::CRC_W-1] ^ b[i];
                crc = {crc[acfc_pkg::CRC_W-2:0], 1'b0} ^ (fb ? acfc_pkg::CRC_POLY : 8'h00);
            end
            return crc;
        endfunction

        // -1 for anything that is not a hex digit
        static function int hex_of(input logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c) - int'("0");
            if (c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F")
                return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void note_char(input logic [7:0] c, input logic is_last);
            int                d;
            acfc_pkg::result_t r;
            if (frame_len != acfc_pkg::LEN_MAX)
                frame_len++;
            if (c == acfc_pkg::CHAR_COMMA)
            begin
                crc_at_comma = crc_run;
                comma_seen   = 1'b1;
                if (tok_len != 0)
                begin
                    if (tokens_closed == 0)
                        verdict = (tok_len == 1 && tok_sign) ? acfc_pkg::FV_SIGN :
                                                               acfc_pkg::FV_OTHER;
                    if (tokens_closed < TOKEN_CAP)
                        tokens_closed++;
                end
                tokens_at_comma = tokens_closed;
                tok_len  = '0;
                tok_sign = 1'b0;
                tail_len = '0;
                tail_hex = 1'b1;
                tail_val = '0;
            end
            else
            begin
                d = hex_of(c);
                if (tok_len == 0)
                    tok_sign = (c == acfc_pkg::CHAR_SIGN);
                if (tok_len < 2)
                    tok_len++;
                if (tail_len < 3)
                    tail_len++;
                if (d < 0)
                    tail_hex = 1'b0;
                else
                    tail_val = {tail_val[3:0], 4'(d)};
            end
            crc_run = crc_step(crc_run, c);
            if (!is_last)
                return;

            r.param_count  = '0;
            r.computed_crc = crc_at_comma;
            if (frame_len >= buffer_size)
                r.status = acfc_pkg::ST_TOO_LONG;
            else if (!comma_seen)
                r.status = acfc_pkg::ST_MALFORMED;
            else if (tail_len == 0 || tail_len > 2 || !tail_hex || tail_val != crc_at_comma)
                r.status = acfc_pkg::ST_BAD_CRC;
            else if (tokens_at_comma < 2)
                r.status = acfc_pkg::ST_MALFORMED;
            else if (verdict != acfc_pkg::FV_SIGN)
                r.status = acfc_pkg::ST_BAD_SIGN;
            else
            begin
                r.status = acfc_pkg::ST_OK;
                r.param_count = (tokens_at_comma - 2 > MAX_PARAMS) ?
                                4'(MAX_PARAMS) : 4'(tokens_at_comma - 4'd2);
            end
            awaited_verdicts.push_back(r);
            clear_frame();
        endfunction

        function void check_verdict(input logic [acfc_pkg::STATUS_W-1:0] st,
                                    input logic [acfc_pkg::PCOUNT_W-1:0] pc,
                                    input logic [acfc_pkg::CRC_W-1:0] crc);
            acfc_pkg::result_t want;
            if (awaited_verdicts.size() == 0)
            begin
                $error("result word with no frame pending: status %0d", st);
                mismatch_count++;
                return;
            end
            want = awaited_verdicts.pop_front();
            if (want.status != st)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                mismatch_count++;
            end
            if (want.param_count != pc)
            begin
                $error("param_count: expected %0d, got %0d", want.param_count, pc);
                mismatch_count++;
            end
            if (want.computed_crc != crc)
            begin
                $error("computed_crc: expected %02h, got %02h", want.computed_crc, crc);
                mismatch_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [acfc_pkg::LEN_W-1:0] cfg_wdata;

    acfc_in_if  in_ch();
    acfc_out_if out_ch();

    ascii_command_frame_checker_core #(
        .MAX_PARAMS (MAX_PARAMS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    frame_checker_model_t model = new();

    logic [7:0] frame_q[$];
    // characters just outside the hex ranges, plus the zero byte and 0xFF
    logic [7:0] non_hex_chars[8] = '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'hFF};

    bit calm;           // both sides stop idling while set
    bit hold_request;   // asks the receiver for one long hold-off
    int hold_left;
    int sent_chars;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // observe both handshakes; the result of a frame is registered when its last word is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                model.check_verdict(out_ch.status, out_ch.param_count,
                                    out_ch.computed_crc);
            if (in_ch.valid && in_ch.ready)
                model.note_char(in_ch.char_byte, in_ch.frame_end);
        end
    end

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == acfc_pkg::CHAR_COMMA)
            c = 8'h00;
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10)
            return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // closes the body in frame_q with a comma and a crc field of the given kind; TAIL_NONE adds nothing
    function automatic void add_tail(input tail_kind_t kind);
        logic [7:0] crc;
        logic [7:0] wrong;
        int n;
        int spot;
        crc = acfc_pkg::CRC_SEED;
        foreach (frame_q[i])
            crc = frame_checker_model_t::crc_step(crc, frame_q[i]);
        if (kind == TAIL_NONE)
            return;
        frame_q.push_back(acfc_pkg::CHAR_COMMA);
        case (kind)
            TAIL_GOOD:
            begin
                // a value below 0x10 may go with or without its leading zero
                if (crc[7:4] != 0 || $urandom_range(1))
                    frame_q.push_back(hex_char(crc[7:4]));
                frame_q.push_back(hex_char(crc[3:0]));
            end
            TAIL_WRONG:
            begin
                wrong = crc ^ 8'($urandom_range(1, 255));
                frame_q.push_back(hex_char(wrong[7:4]));
                frame_q.push_back(hex_char(wrong[3:0]));
            end
            TAIL_LONG:
            begin
                n = $urandom_range(3, 5);
                repeat (n) frame_q.push_back(hex_char(4'($urandom_range(15))));
            end
            TAIL_NON_HEX:
            begin
                n    = $urandom_range(1, 2);
                spot = $urandom_range(n - 1);
                for (int i = 0; i < n; i++)
                    frame_q.push_back((i == spot) ? non_hex_chars[$urandom_range(7)] :
                                      hex_char(4'($urandom_range(15))));
            end
            default: ;  // comma as the last word
        endcase
    endfunction

    // tokens: count incl. sign and command; gap_pct: chance of extra empty tokens
    function automatic void build_frame(input int tokens, input bit exact_sign,
                                        input int gap_pct, input tail_kind_t tail);
        int len;
        logic [7:0] c;
        frame_q.delete();
        for (int t = 0; t < tokens; t++)
        begin
            if (t != 0)
                frame_q.push_back(acfc_pkg::CHAR_COMMA);
            while ($urandom_range(99) < gap_pct)
                frame_q.push_back(acfc_pkg::CHAR_COMMA);
            if (t == 0 && exact_sign)
                frame_q.push_back(acfc_pkg::CHAR_SIGN);
            else if (t == 0)
            begin
                // first token close to the sign but not exactly it
                case ($urandom_range(2))
                    0:
                    begin
                        frame_q.push_back(acfc_pkg::CHAR_SIGN);
                        frame_q.push_back(acfc_pkg::CHAR_SIGN);
                    end
                    1:
                    begin
                        frame_q.push_back(acfc_pkg::CHAR_SIGN);
                        frame_q.push_back(token_char());
                    end
                    default:
                    begin
                        do c = token_char(); while (c == acfc_pkg::CHAR_SIGN);
                        frame_q.push_back(c);
                    end
                endcase
            end
            else
            begin
                len = $urandom_range(1, 4);
                repeat (len) frame_q.push_back(token_char());
            end
        end
        add_tail(tail);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic is_last);
        while (!calm && $urandom_range(99) < 28)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_byte <= c;
        in_ch.frame_end <= is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_chars++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_char(frame_q[i], i == frame_q.size() - 1);
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic send_random_frame();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 55)
            build_frame($urandom_range(2, 12), 1'b1, ($urandom_range(2) == 0) ? 15 : 0,
                        TAIL_GOOD);
        else if (pick < 62)
            build_frame($urandom_range(2, 8), 1'b1, 0, TAIL_WRONG);
        else if (pick < 67)
            build_frame($urandom_range(2, 8), 1'b1, 0, TAIL_LONG);
        else if (pick < 72)
            build_frame($urandom_range(2, 8), 1'b1, 0, TAIL_NON_HEX);
        else if (pick < 76)
            build_frame($urandom_range(1, 8), 1'b1, 0, TAIL_EMPTY);
        else if (pick < 80)
            build_frame(1, 1'($urandom_range(1)), 0, TAIL_NONE);
        else if (pick < 85)
            build_frame($urandom_range(0, 1), 1'b1, 10, TAIL_GOOD);
        else if (pick < 92)
            build_frame($urandom_range(2, 6), 1'b0, 10, TAIL_GOOD);
        else
        begin
            frame_q.delete();
            n = $urandom_range(1, 16);
            repeat (n)
                frame_q.push_back(($urandom_range(4) == 0) ? acfc_pkg::CHAR_COMMA :
                                  8'($urandom_range(255)));
        end
        send_frame();
    endtask

    // drop valid, wait for every owed verdict, then let the pipeline empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_buffer_size(input logic [acfc_pkg::LEN_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        model.buffer_size = v;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int random_start;
        bit pressured;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.char_byte = '0;
        in_ch.frame_end = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        calm            = 1'b0;
        hold_request    = 1'b0;
        sent_chars      = 0;
        pressured       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at the reset buffer size
        frame_q = '{acfc_pkg::CHAR_SIGN, acfc_pkg::CHAR_COMMA, 8'h63};
        add_tail(TAIL_GOOD);
        send_frame();
        // zero byte and top byte inside a parameter
        frame_q = '{acfc_pkg::CHAR_SIGN, acfc_pkg::CHAR_COMMA, 8'h01, acfc_pkg::CHAR_COMMA,
                    8'h00, 8'hFF};
        add_tail(TAIL_GOOD);
        send_frame();
        // single word frame, no comma
        frame_q = '{acfc_pkg::CHAR_SIGN};
        send_frame();
        // comma as the last word
        frame_q = '{acfc_pkg::CHAR_SIGN, acfc_pkg::CHAR_COMMA, 8'h63};
        add_tail(TAIL_EMPTY);
        send_frame();
        // wrong first token
        frame_q = '{8'h78, acfc_pkg::CHAR_COMMA, 8'h63};
        add_tail(TAIL_GOOD);
        send_frame();
        // more parameters than the cap, empty tokens, overlong crc field
        build_frame(13, 1'b1, 0, TAIL_GOOD);
        send_frame();
        build_frame(3, 1'b1, 40, TAIL_GOOD);
        send_frame();
        build_frame(2, 1'b1, 0, TAIL_LONG);
        send_frame();

        // zero and one: every frame is too long
        set_buffer_size('0);
        repeat (4) send_random_frame();
        set_buffer_size(13'd1);
        repeat (4) send_random_frame();

        // largest buffer size
        set_buffer_size(acfc_pkg::LEN_MAX);
        repeat (2) send_random_frame();

        // back-to-back stretch with no idling on either side
        set_buffer_size(13'd4096);
        calm = 1'b1;
        random_start = sent_chars;
        while (sent_chars - random_start < 300)
            send_random_frame();
        calm = 1'b0;

        // random phases with random buffer sizes
        random_start = sent_chars;
        while (sent_chars - random_start < 700)
        begin
            case ($urandom_range(3))
                0: set_buffer_size(acfc_pkg::LEN_W'($urandom_range(2, 40)));
                1: set_buffer_size(acfc_pkg::BUF_SIZE_RST);
                2: set_buffer_size(acfc_pkg::LEN_W'($urandom_range(1, 4096)));
                default: set_buffer_size(13'd4096);
            endcase
            // one long receiver hold-off while words keep coming
            if (!pressured)
            begin
                hold_request = 1'b1;
                pressured    = 1'b1;
            end
            repeat ($urandom_range(8, 20)) send_random_frame();
        end

        settle();
        repeat (5) @(posedge clk);
        if (model.mismatch_count == 0 && model.awaited_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: ascii_command_frame_checker_core.f
rtl/acfc_pkg.sv
rtl/acfc_if.sv
rtl/acfc_tracker.sv
rtl/acfc_out_reg.sv
rtl/ascii_command_frame_checker_core.sv
rtl/acfc_checker.sv
test/ascii_command_frame_checker_core_tb.sv
